### design/tss_pkg.sv
package tss_pkg;

    // field widths
    localparam int TARGET_W = 32;
    localparam int TIME_W   = 24;
    localparam int PRE_W    = 3;
    localparam int CODE_W   = 8;

    // internal widths
    localparam int NUM_W    = 20;   // dividend: ticks
    localparam int DEN_W    = 5;    // divisor: postscale up to 16
    localparam int TICKS_W  = 20;   // ticks <= 522240
    localparam int TICKA_W  = 26;   // 4*target+62 <= 65280062
    localparam int RECIP_W  = 27;
    localparam int TPROD_W  = TICKA_W + RECIP_W;
    localparam int RECIP_SH = 33;
    localparam int STEP_W   = 5;
    localparam int POST_W   = 5;    // postscale 1..16
    localparam int NQ_W     = 12;   // period*postscale <= 4080
    localparam int PROD_W   = 19;   // 125*period*postscale
    localparam int SCALE_W  = 26;   // product shifted by prescale

    // constants of the timer
    localparam logic [TARGET_W-1:0] TARGET_LIMIT_NS = 32'd16320000;
    // (target*100+1562)/3125 equals (4*target+62)/125
    localparam logic [5:0]          TICK_RND4    = 6'd62;
    localparam logic [RECIP_W-1:0]  RECIP_125    = 27'd68719477;  // ceil(2^33/125)
    localparam logic [6:0]          TICK_PER_4   = 7'd125;   // 3125/100 = 125/4
    localparam logic [CODE_W-1:0]   MAX_PERIOD   = 8'd255;
    localparam logic [POST_W-1:0]   MAX_POST     = 5'd16;
    localparam logic [PRE_W-1:0]    MAX_PRE      = 3'd7;
    localparam logic [STEP_W-1:0]   REM_STEPS    = 5'd20;

    // controller to datapath
    typedef struct packed {
        logic              load;       // capture target, clear best
        logic              div_start;
        logic              ld_ticks;
        logic              ld_rem;
        logic              cand_a;     // period and period*postscale
        logic              cand_b;     // scaled time
        logic              cand_c;     // error compare and update
        logic [POST_W-1:0] post;
        logic [PRE_W-1:0]  pre;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic over;
    } t_sts;

endpackage

### design/tss_div.sv
module tss_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tss_pkg::NUM_W-1:0]  i_num,
    input  logic [tss_pkg::DEN_W-1:0]  i_den,
    input  logic [tss_pkg::STEP_W-1:0] i_steps,
    output logic [tss_pkg::TICKS_W-1:0] o_quo,
    output logic                       o_done
);

    logic [tss_pkg::NUM_W-1:0]  r_num;
    logic [tss_pkg::DEN_W-1:0]  r_den;
    logic [tss_pkg::DEN_W-1:0]  r_rem;
    logic [tss_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [tss_pkg::DEN_W:0]    shifted;
    logic                       fits;

    // restoring division, one quotient bit per cycle, msb first
    always_comb begin
        shifted = {r_rem, r_num[tss_pkg::NUM_W-1]};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1'b1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[tss_pkg::NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= tss_pkg::DEN_W'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[tss_pkg::DEN_W-1:0];
            end
        end
    end

    assign o_quo  = r_num[tss_pkg::TICKS_W-1:0];
    assign o_done = r_done;

endmodule

### design/tss_datapath.sv
module tss_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tss_pkg::t_cmd                i_cmd,
    output tss_pkg::t_sts                o_sts,
    input  logic [tss_pkg::TARGET_W-1:0] i_target_ns,
    output logic [tss_pkg::TIME_W-1:0]   o_achieved_ns,
    output logic [tss_pkg::PRE_W-1:0]    o_prescale_code,
    output logic [tss_pkg::CODE_W-1:0]   o_postscale_code,
    output logic [tss_pkg::CODE_W-1:0]   o_period_code,
    output logic                         o_found
);

    logic [tss_pkg::TIME_W-1:0]   r_target;
    logic                         r_over;
    logic [tss_pkg::TICKS_W-1:0]  r_ticks;
    logic [tss_pkg::TICKS_W-1:0]  r_rem;
    logic [tss_pkg::CODE_W-1:0]   r_per;
    logic                         r_ok_a;
    logic                         r_ok_b;
    logic [tss_pkg::NQ_W-1:0]     r_nq;
    logic [tss_pkg::TIME_W-1:0]   r_t;
    logic [tss_pkg::CODE_W-1:0]   r_per_b;
    logic [tss_pkg::TIME_W-1:0]   r_best_t;
    logic [tss_pkg::TIME_W-1:0]   r_best_err;
    logic [tss_pkg::PRE_W-1:0]    r_best_p;
    logic [tss_pkg::POST_W-1:0]   r_best_q;
    logic [tss_pkg::CODE_W-1:0]   r_best_n;

    logic [tss_pkg::TICKA_W-1:0]  tick_a;
    logic [tss_pkg::TPROD_W-1:0]  tick_prod;
    logic [tss_pkg::TICKS_W-1:0]  tick_cnt;
    logic [tss_pkg::NUM_W-1:0]    div_num;
    logic [tss_pkg::DEN_W-1:0]    div_den;
    logic [tss_pkg::STEP_W-1:0]   div_steps;
    logic [tss_pkg::TICKS_W-1:0]  div_quo;
    logic                         div_done;
    logic [tss_pkg::TICKS_W-1:0]  shr;
    logic [tss_pkg::TICKS_W:0]    rnd;
    logic [tss_pkg::TICKS_W-1:0]  per;
    logic                         per_ok;
    logic [tss_pkg::PROD_W-1:0]   prod;
    logic [tss_pkg::SCALE_W-1:0]  scaled;
    logic [tss_pkg::TIME_W-1:0]   err;

    // target to ticks by reciprocal multiply, exact for every in-range target
    always_comb begin
        tick_a    = {r_target, 2'b00} + tss_pkg::TICKA_W'(tss_pkg::TICK_RND4);
        tick_prod = tss_pkg::TPROD_W'(tick_a) * tss_pkg::TPROD_W'(tss_pkg::RECIP_125);
        tick_cnt  = tick_prod[tss_pkg::RECIP_SH +: tss_pkg::TICKS_W];
    end

    // divider operands: ticks by postscale
    assign div_num   = tss_pkg::NUM_W'(r_ticks);
    assign div_den   = tss_pkg::DEN_W'(i_cmd.post);
    assign div_steps = tss_pkg::REM_STEPS;

    tss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // period for this prescale, rounded half up when shifted
    always_comb begin
        shr    = r_rem >> (i_cmd.pre - 1'b1);
        rnd    = ({1'b0, shr} + 1'b1) >> 1;
        per    = (i_cmd.pre == '0) ? r_rem : rnd[tss_pkg::TICKS_W-1:0];
        per_ok = (per >= 1) && (per <= tss_pkg::TICKS_W'(tss_pkg::MAX_PERIOD))
              && ((per > 1) || (i_cmd.pre != '0));
        prod   = tss_pkg::PROD_W'(r_nq) * tss_pkg::PROD_W'(tss_pkg::TICK_PER_4);
        scaled = tss_pkg::SCALE_W'(prod) << i_cmd.pre;
        err    = (r_t >= r_target) ? (r_t - r_target) : (r_target - r_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target   <= i_target_ns[tss_pkg::TIME_W-1:0];
            r_over     <= i_target_ns > tss_pkg::TARGET_LIMIT_NS;
            r_best_err <= i_target_ns[tss_pkg::TIME_W-1:0];
            r_best_t   <= '0;
            r_best_p   <= '0;
            r_best_q   <= '0;
            r_best_n   <= '0;
        end
        if (i_cmd.ld_ticks) begin
            r_ticks <= tick_cnt;
        end
        if (i_cmd.ld_rem) begin
            r_rem <= div_quo;
        end
        if (i_cmd.cand_a) begin
            r_per  <= per[tss_pkg::CODE_W-1:0];
            r_ok_a <= per_ok;
            r_nq   <= tss_pkg::NQ_W'(per[tss_pkg::CODE_W-1:0])
                    * tss_pkg::NQ_W'(i_cmd.post);
        end
        if (i_cmd.cand_b) begin
            r_t     <= scaled[tss_pkg::SCALE_W-1:2];
            r_ok_b  <= r_ok_a;
            r_per_b <= r_per;
        end
        if (i_cmd.cand_c && r_ok_b && (err < r_best_err)) begin
            r_best_err <= err;
            r_best_t   <= r_t;
            r_best_p   <= i_cmd.pre;
            r_best_q   <= i_cmd.post;
            r_best_n   <= r_per_b;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.over     = r_over;

    // no candidate: postscale and period codes wrap to all ones
    assign o_achieved_ns    = r_best_t;
    assign o_found          = r_best_t != '0;
    assign o_prescale_code  = r_over ? '0 : r_best_p;
    assign o_postscale_code = r_over ? '0 : tss_pkg::CODE_W'(r_best_q) - 1'b1;
    assign o_period_code    = r_over ? '0 : r_best_n - 1'b1;

endmodule

### design/tss_ctrl.sv
module tss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tss_pkg::t_sts i_sts,
    output tss_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_QDIV,
        S_QWAIT,
        S_CA,
        S_CB,
        S_CC,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [tss_pkg::POST_W-1:0]  r_q;
    logic [tss_pkg::PRE_W-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
            r_p     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_q <= tss_pkg::MAX_POST;
                    if (i_sts.over) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (i_sts.div_done) begin
                        r_p     <= tss_pkg::MAX_PRE;
                        r_state <= S_CA;
                    end
                end
                S_CA: begin
                    r_state <= S_CB;
                end
                S_CB: begin
                    r_state <= S_CC;
                end
                S_CC: begin
                    if (r_p != '0) begin
                        r_p     <= r_p - 1'b1;
                        r_state <= S_CA;
                    end else if (r_q == 1'b1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_q     <= r_q - 1'b1;
                        r_state <= S_QDIV;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.post      = r_q;
        o_cmd.pre       = r_p;
        o_cmd.load      = (r_state == S_IDLE) && i_start;
        o_cmd.div_start = r_state == S_QDIV;
        o_cmd.ld_ticks  = (r_state == S_CHK) && !i_sts.over;
        o_cmd.ld_rem    = (r_state == S_QWAIT) && i_sts.div_done;
        o_cmd.cand_a    = r_state == S_CA;
        o_cmd.cand_b    = r_state == S_CB;
        o_cmd.cand_c    = r_state == S_CC;
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_state == S_DONE;

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe lasted more than one cycle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && i_start) |=> (r_state == S_CHK))
        else $error("accepted transaction not started");

    a_post_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CA) |-> ((r_q != '0) && (r_q <= tss_pkg::MAX_POST)))
        else $error("postscale out of range during evaluation");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_QWAIT))
        else $error("divider finished outside a wait state");

endmodule

### design/timer_scaler_search_top.sv
// timer scaler search: start a transaction with a target interval in ns while busy is low;
// the block searches postscale 16..1, prescale 7..0 and the matching period for the
// setting of a 32 MHz timer closest to the target and shows the best one on the
// result ports for exactly one cycle, marked by o_valid. the receiver cannot stall,
// so o_valid must be sampled every cycle. for an in-range target busy stays high for
// the range check and the tick count by reciprocal multiply, then per postscale a
// launch state, a wait on a 20-step serial division by the postscale and 8 candidates
// each in the states S_CA, S_CB and S_CC, with the result cycle last. a target
// above 16,320,000 ns goes from the range check straight to the result cycle and
// gives all fields zero. busy stays high from acceptance through the result cycle,
// so a new transaction is taken only once the result cycle is over.
module timer_scaler_search_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tss_pkg::TARGET_W-1:0] i_target_ns,
    output logic                         o_valid,
    output logic [tss_pkg::TIME_W-1:0]   o_achieved_ns,
    output logic [tss_pkg::PRE_W-1:0]    o_prescale_code,
    output logic [tss_pkg::CODE_W-1:0]   o_postscale_code,
    output logic [tss_pkg::CODE_W-1:0]   o_period_code,
    output logic                         o_found
);

    // command and status between sequencer and datapath
    tss_pkg::t_cmd cmd;
    tss_pkg::t_sts sts;

    // sequencer: walks postscale and prescale, issues divider and candidate steps
    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // datapath: tick multiply, serial divider, candidate pipeline and best-so-far registers
    tss_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_target_ns      (i_target_ns),
        .o_achieved_ns    (o_achieved_ns),
        .o_prescale_code  (o_prescale_code),
        .o_postscale_code (o_postscale_code),
        .o_period_code    (o_period_code),
        .o_found          (o_found)
    );

endmodule

### test/timer_scaler_search_top_test.sv
`timescale 1ns / 100ps

module timer_scaler_search_top_test;

    // run size and limits
    localparam int     N_ITEMS      = 1170;
    localparam int     DRAIN_CYCLES = 1000;     // a bit more than one full search
    localparam longint CYCLE_LIMIT  = 5_000_000;

    // timer constants for the expected results
    localparam logic [tss_pkg::TARGET_W-1:0] TARGET_LIMIT_NS = 32'd16320000;
    localparam longint unsigned NS_TO_PS10  = 100;
    localparam longint unsigned TICK_HALF10 = 1562;
    localparam longint unsigned TICK_PS10   = 3125;
    localparam longint unsigned MAX_PERIOD  = 255;
    localparam int              MAX_POST    = 16;
    localparam int              MAX_PRE     = 7;

    // one result transaction of the block
    typedef struct packed {
        logic [tss_pkg::TIME_W-1:0] achieved_ns;
        logic [tss_pkg::PRE_W-1:0]  prescale_code;
        logic [tss_pkg::CODE_W-1:0] postscale_code;
        logic [tss_pkg::CODE_W-1:0] period_code;
        logic                       found;
    } t_setting;

    // one pending request: the target and the idle cycles that follow its launch
    typedef struct {
        logic [tss_pkg::TARGET_W-1:0] target;
        int unsigned                  gap;
    } t_request;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic [tss_pkg::TARGET_W-1:0] i_target_ns = '0;
    logic                         busy;
    logic                         o_valid;
    logic [tss_pkg::TIME_W-1:0]   o_achieved_ns;
    logic [tss_pkg::PRE_W-1:0]    o_prescale_code;
    logic [tss_pkg::CODE_W-1:0]   o_postscale_code;
    logic [tss_pkg::CODE_W-1:0]   o_period_code;
    logic                         o_found;

    t_request    pending_targets[$];
    t_setting    expected_settings[$];
    int unsigned gap_left   = 0;
    int          n_total    = 0;
    int          n_accepted = 0;
    int          n_over     = 0;
    int          n_found    = 0;
    int          n_none     = 0;
    int          n_mismatch = 0;
    longint      cycle_cnt  = 0;

    timer_scaler_search_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_target_ns      (i_target_ns),
        .o_valid          (o_valid),
        .o_achieved_ns    (o_achieved_ns),
        .o_prescale_code  (o_prescale_code),
        .o_postscale_code (o_postscale_code),
        .o_period_code    (o_period_code),
        .o_found          (o_found)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // synchronous reset, held low from the start and released once
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // true distance between two intervals, no wrap-around
    function automatic longint unsigned ns_distance(input longint unsigned a,
                                                    input longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // exhaustive search over postscale 16..1, prescale 7..0 for the closest interval;
    // a strictly smaller error is needed to replace the best, so ties keep the earlier one
    function automatic t_setting calc_best_setting(input logic [tss_pkg::TARGET_W-1:0] target);
        t_setting          best;
        longint unsigned   tgt, ticks, rem, per, t_ns;
        longint unsigned   best_ns, best_q, best_p, best_n;
        best    = '0;
        tgt     = target;
        best_ns = 0;
        best_q  = 0;
        best_p  = 0;
        best_n  = 0;
        // too large: everything zero, codes included
        if (tgt > TARGET_LIMIT_NS)
            return best;
        // round the target to 31.25 ns ticks
        ticks = (tgt * NS_TO_PS10 + TICK_HALF10) / TICK_PS10;
        for (int q = MAX_POST; q >= 1; q--) begin
            rem = ticks / q;
            for (int p = MAX_PRE; p >= 0; p--) begin
                // period is rem / 2^p rounded half up, or rem itself without a prescaler
                per = (p == 0) ? rem : (((rem >> (p - 1)) + 1) >> 1);
                // a period of 1 is only legal behind a prescaler
                if (per >= 1 && per <= MAX_PERIOD && (per > 1 || p > 0)) begin
                    t_ns = ((TICK_PS10 << p) * per * q) / NS_TO_PS10;
                    if (ns_distance(t_ns, tgt) < ns_distance(best_ns, tgt)) begin
                        best_ns = t_ns;
                        best_q  = q;
                        best_p  = p;
                        best_n  = per;
                    end
                end
            end
        end
        // nothing qualified: the minus-one codes wrap to all ones
        best.achieved_ns    = best_ns[tss_pkg::TIME_W-1:0];
        best.prescale_code  = best_p[tss_pkg::PRE_W-1:0];
        best.postscale_code = tss_pkg::CODE_W'(best_q - 1);
        best.period_code    = tss_pkg::CODE_W'(best_n - 1);
        best.found          = (best_ns != 0);
        return best;
    endfunction

    // request driver: a transaction is taken at an edge with start high and busy low;
    // start then either drops for the gap or moves straight on to the next target.
    // the gap counts down while the block is busy, so the next start lands on any
    // phase of the search, early, late or after the result
    always @(posedge i_clk) begin : drive
        t_request nxt;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_target_ns <= '0;
            gap_left    <= 0;
        end else begin
            if (start && !busy) begin
                expected_settings.push_back(calc_best_setting(i_target_ns));
                n_accepted++;
                if (i_target_ns > TARGET_LIMIT_NS)
                    n_over++;
            end
            // a held start stays put until it is taken
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (pending_targets.size() != 0) begin
                    nxt = pending_targets.pop_front();
                    i_target_ns <= nxt.target;
                    start       <= 1'b1;
                    gap_left    <= nxt.gap;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: o_valid lasts one cycle and cannot be stalled, so look every edge
    always @(posedge i_clk) begin : check
        t_setting want;
        if (i_rst_n && o_valid) begin
            if (expected_settings.size() == 0) begin
                $error("result with no transaction outstanding: achieved_ns %0d",
                       o_achieved_ns);
                n_mismatch++;
            end else begin
                want = expected_settings.pop_front();
                if (o_achieved_ns !== want.achieved_ns) begin
                    $error("achieved_ns: expected %0d, got %0d",
                           want.achieved_ns, o_achieved_ns);
                    n_mismatch++;
                end
                if (o_prescale_code !== want.prescale_code) begin
                    $error("prescale_code: expected %0d, got %0d",
                           want.prescale_code, o_prescale_code);
                    n_mismatch++;
                end
                if (o_postscale_code !== want.postscale_code) begin
                    $error("postscale_code: expected %0d, got %0d",
                           want.postscale_code, o_postscale_code);
                    n_mismatch++;
                end
                if (o_period_code !== want.period_code) begin
                    $error("period_code: expected %0d, got %0d",
                           want.period_code, o_period_code);
                    n_mismatch++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    n_mismatch++;
                end
                if (want.found)
                    n_found++;
                else
                    n_none++;
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d transactions taken",
                     cycle_cnt, n_accepted, n_total);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [tss_pkg::TARGET_W-1:0] directed_targets[$];
        longint unsigned              t_ns;
        int                           kind;
        int                           burst_left;
        int unsigned                  gap;
        int unsigned                  shift;
        int                           sel_p, sel_q, sel_n;

        // directed: nothing qualifies, smallest legal settings, exact hits,
        // the range limit and targets above it
        directed_targets = '{
            32'd0, 32'd1, 32'd15, 32'd16, 32'd31, 32'd32, 32'd62, 32'd63,
            32'd94, 32'd100, 32'd1000, 32'd31250, 32'd1000000, 32'd5000000,
            32'd12345678, TARGET_LIMIT_NS - 1, TARGET_LIMIT_NS, TARGET_LIMIT_NS + 1,
            32'h00FF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'hFFFF_FFFF
        };
        foreach (directed_targets[i])
            pending_targets.push_back('{directed_targets[i], $urandom_range(0, 3)});

        // random part, mostly in range since those run the full search
        burst_left = 0;
        while (pending_targets.size() < N_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                t_ns = $urandom_range(0, TARGET_LIMIT_NS);
            end else if (kind < 70) begin
                // spread over magnitudes, small targets included
                shift = $urandom_range(0, 24);
                t_ns  = $urandom & ((32'd1 << shift) - 1);
            end else if (kind < 85) begin
                // at or just beside an interval some setting reaches exactly
                sel_p = $urandom_range(0, 7);
                sel_q = $urandom_range(1, 16);
                sel_n = $urandom_range(1, 255);
                t_ns  = ((64'd3125 << sel_p) * sel_n * sel_q) / 100;
                t_ns  = t_ns + $urandom_range(0, 6);
                t_ns  = (t_ns > 3) ? t_ns - 3 : 0;
            end else if (kind < 90) begin
                t_ns = TARGET_LIMIT_NS - 8 + $urandom_range(0, 16);
            end else begin
                // full width, exercises the upper target bits
                t_ns = $urandom;
            end

            // sender gaps: stretches without any, then mostly short, a few long
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else if ($urandom_range(0, 39) == 0) begin
                burst_left = $urandom_range(10, 40);
                gap = 0;
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 45)
                    gap = 0;
                else if (kind < 80)
                    gap = $urandom_range(1, 3);
                else if (kind < 97)
                    gap = $urandom_range(4, 40);
                else
                    gap = $urandom_range(100, 1200);
            end
            pending_targets.push_back('{t_ns[tss_pkg::TARGET_W-1:0], gap});
        end
        n_total = pending_targets.size();

        wait (i_rst_n);
        while (n_accepted < n_total || expected_settings.size() != 0)
            @(posedge i_clk);
        // nothing may show up after the last expected result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions in %0d cycles: %0d with a setting, %0d with none",
                 n_accepted, cycle_cnt, n_found, n_none - n_over);
        $display("%0d targets above the maximum interval", n_over);
        if (n_mismatch == 0 && expected_settings.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
